// ===== rtl/lever_press_duration_classifier_macros.svh =====
// assertion macros shared by the lever press classifier checkers
// no dependencies; included by the checker file only
`ifndef LEVER_PRESS_DURATION_CLASSIFIER_MACROS_SVH
`define LEVER_PRESS_DURATION_CLASSIFIER_MACROS_SVH

// concurrent check, quiet while reset is asserted
`define LPDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// concurrent check that also holds during reset
`define LPDC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

// ===== rtl/lpdc_pkg.sv =====
// shared types and constants for the lever press duration classifier
// no dependencies; used by the top level and its checker
`timescale 1ns / 1ps

package lpdc_pkg;

  localparam int unsigned NUM_LEVERS_DEF = 2;

  localparam int unsigned LEVER_W = 1;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned FLAG_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [TICK_W-1:0] SHORT_TICKS_RST     = 16'd10;
  localparam logic [TICK_W-1:0] LONG_TICKS_RST      = 16'd200;
  localparam logic [TICK_W-1:0] VERY_LONG_TICKS_RST = 16'd800;
  localparam logic [TICK_W-1:0] TICK_MAX            = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PRESSED = 2'd1,
    ST_POPPED  = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_TICKS     = 2'd0,
    REG_LONG_TICKS      = 2'd1,
    REG_VERY_LONG_TICKS = 2'd2
  } cfg_reg_t;

  localparam logic [FLAG_W-1:0] FL_SHORT     = 4'b0001;
  localparam logic [FLAG_W-1:0] FL_LONG      = 4'b0010;
  localparam logic [FLAG_W-1:0] FL_VLONG     = 4'b0100;
  localparam logic [FLAG_W-1:0] FL_POP       = 4'b1000;
  localparam logic [FLAG_W-1:0] FL_PRESS_ALL = 4'b0111;

endpackage

// ===== rtl/lever_press_duration_classifier.sv =====
// lever press duration classifier top level: input register, per-lever state, result register
// depends on lpdc_pkg
`timescale 1ns / 1ps

// usage
// - in_ channel: one tick transaction per lever sample; tdata carries the lever index,
//   the sampled value (zero means released) and a mask of event flags to acknowledge
// - out_ channel: exactly one result transaction per input transaction, in order,
//   giving the lever's recorded value, press status, held tick count and event flags
// - cfg_ channel: writes short_ticks (0), long_ticks (1), very_long_ticks (2);
//   other indexes are ignored; cfg_ready is always high; write only while idle
// - path: a taken transaction waits in the input register, then its result is captured
//   in the result register, which drives out_
// - throughput: one transaction per cycle while out_tready is high, set by the single
//   per-lever update step (a few compares and one 16 bit increment between input and
//   result registers); back-to-back transactions on the same lever see each other's update
// - stall: if out_tready is low the result register holds and the input register
//   still takes one more transaction; then in_tready drops until the result leaves
// - reset: all lever state is cleared to idle with zero value, timer and flags,
//   the thresholds return to 10 / 200 / 800 and both registers are emptied

module lever_press_duration_classifier #(
  parameter int unsigned NUM_LEVERS = lpdc_pkg::NUM_LEVERS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input transaction
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [0] lever_index, [16:1] lever_value, [20:17] clear_mask, [23:21] zero
  input  logic [lpdc_pkg::IN_DATA_W-1:0]       in_tdata,
  // result transaction
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [0] lever_out, [16:1] current_value, [18:17] press_status,
  // [34:19] held_ticks, [38:35] event_flags, [39] zero
  output logic [lpdc_pkg::OUT_DATA_W-1:0]      out_tdata,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lpdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lpdc_pkg::TICK_W-1:0]          cfg_data
);

  localparam int unsigned IDX_W = (NUM_LEVERS > 1) ? $clog2(NUM_LEVERS) : 1;

  // thresholds
  logic [lpdc_pkg::TICK_W-1:0] short_ticks_r;
  logic [lpdc_pkg::TICK_W-1:0] long_ticks_r;
  logic [lpdc_pkg::TICK_W-1:0] very_long_ticks_r;

  // per-lever state
  logic [lpdc_pkg::VALUE_W-1:0] last_value_r   [NUM_LEVERS];
  lpdc_pkg::status_t            status_store_r [NUM_LEVERS];
  logic [lpdc_pkg::TICK_W-1:0]  timer_store_r  [NUM_LEVERS];
  logic [lpdc_pkg::FLAG_W-1:0]  flag_store_r   [NUM_LEVERS];

  // input register
  logic                          in_vld_r;
  logic [lpdc_pkg::LEVER_W-1:0]  lever_r;
  logic [lpdc_pkg::VALUE_W-1:0]  value_r;
  logic [lpdc_pkg::FLAG_W-1:0]   mask_r;

  // result register
  logic                          out_vld_r;
  logic [lpdc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [lpdc_pkg::OUT_DATA_W-1:0] out_data_nxt;

  // update step
  logic                          advance;
  logic                          in_range;
  logic [IDX_W-1:0]              sel;
  logic [lpdc_pkg::VALUE_W-1:0]  value_nxt;
  lpdc_pkg::status_t             status_nxt;
  logic [lpdc_pkg::TICK_W-1:0]   timer_nxt;
  logic [lpdc_pkg::FLAG_W-1:0]   flags_nxt;

  // result stage moves when empty or drained this cycle
  assign advance   = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  assign sel      = IDX_W'(lever_r);
  assign in_range = (int'(lever_r) < NUM_LEVERS);

  // one tick of the press classifier for the addressed lever
  always_comb begin
    value_nxt  = last_value_r[sel];
    status_nxt = status_store_r[sel];
    timer_nxt  = timer_store_r[sel];
    // acknowledge first
    flags_nxt  = flag_store_r[sel] & ~mask_r;

    if (value_nxt != value_r) begin
      value_nxt = value_r;
      if (value_r != '0) begin
        // new press
        status_nxt = lpdc_pkg::ST_PRESSED;
        timer_nxt  = '0;
        flags_nxt  = flags_nxt & ~lpdc_pkg::FL_PRESS_ALL;
      end else if (timer_nxt >= short_ticks_r) begin
        status_nxt = lpdc_pkg::ST_POPPED;
        flags_nxt  = flags_nxt | lpdc_pkg::FL_POP;
      end else begin
        status_nxt = lpdc_pkg::ST_IDLE;
      end
    end

    if (status_nxt == lpdc_pkg::ST_PRESSED) begin
      // saturating count
      if (timer_nxt != lpdc_pkg::TICK_MAX) begin
        timer_nxt = timer_nxt + 1'b1;
      end
      // very long wins over long, long over short
      if (timer_nxt == very_long_ticks_r) begin
        flags_nxt = flags_nxt | lpdc_pkg::FL_VLONG;
      end else if (timer_nxt == long_ticks_r) begin
        flags_nxt = flags_nxt | lpdc_pkg::FL_LONG;
      end else if (timer_nxt == short_ticks_r) begin
        flags_nxt = flags_nxt | lpdc_pkg::FL_SHORT;
      end
      if (timer_nxt > very_long_ticks_r) begin
        status_nxt = lpdc_pkg::ST_TIMEOUT;
      end
    end

    if (in_range) begin
      out_data_nxt = {1'b0, flags_nxt, timer_nxt, status_nxt, value_nxt, lever_r};
    end else begin
      // lever not present: report zeros
      out_data_nxt = {{(lpdc_pkg::OUT_DATA_W - lpdc_pkg::LEVER_W){1'b0}}, lever_r};
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_ticks_r     <= lpdc_pkg::SHORT_TICKS_RST;
      long_ticks_r      <= lpdc_pkg::LONG_TICKS_RST;
      very_long_ticks_r <= lpdc_pkg::VERY_LONG_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lpdc_pkg::REG_SHORT_TICKS:     short_ticks_r     <= cfg_data;
        lpdc_pkg::REG_LONG_TICKS:      long_ticks_r      <= cfg_data;
        lpdc_pkg::REG_VERY_LONG_TICKS: very_long_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      lever_r <= in_tdata[0];
      value_r <= in_tdata[16:1];
      mask_r  <= in_tdata[20:17];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  // per-lever state, written as the result is captured
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVERS; i++) begin
        last_value_r[i]   <= '0;
        status_store_r[i] <= lpdc_pkg::ST_IDLE;
        timer_store_r[i]  <= '0;
        flag_store_r[i]   <= '0;
      end
    end else if (advance && in_vld_r && in_range) begin
      last_value_r[sel]   <= value_nxt;
      status_store_r[sel] <= status_nxt;
      timer_store_r[sel]  <= timer_nxt;
      flag_store_r[sel]   <= flags_nxt;
    end
  end

endmodule

// ===== rtl/lpdc_checker.sv =====
// port-level checks for the lever press duration classifier, bound to the top level
// depends on lpdc_pkg and lever_press_duration_classifier_macros.svh
`timescale 1ns / 1ps
`include "lever_press_duration_classifier_macros.svh"

module lpdc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lpdc_pkg::OUT_DATA_W-1:0]  out_tdata
);

  logic [1:0]  status;
  logic [15:0] value;

  assign status = out_tdata[18:17];
  assign value  = out_tdata[16:1];

  // stalled result holds
  `LPDC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // reset empties the result stage
  `LPDC_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "result valid right after reset")

  // an empty result stage never blocks the input
  `LPDC_ASSERT(a_no_block, !out_tvalid |-> in_tready, "input blocked with empty result stage")

  // held or timed out presses carry a nonzero value
  `LPDC_ASSERT(a_press_val, out_tvalid && (status == lpdc_pkg::ST_PRESSED || status == lpdc_pkg::ST_TIMEOUT) |-> value != '0, "press status with zero value")

  // idle and popped mean released
  `LPDC_ASSERT(a_rel_val, out_tvalid && (status == lpdc_pkg::ST_IDLE || status == lpdc_pkg::ST_POPPED) |-> value == '0, "released status with nonzero value")

endmodule

bind lever_press_duration_classifier lpdc_checker u_lpdc_checker (.*);

// ===== test/lever_press_duration_classifier_checker.sv =====
// result checker for the lever press duration classifier: watches the tick, result and
// register write channels, predicts every result and compares it field by field
// depends on lpdc_pkg
`timescale 1ns / 1ps

module lever_press_duration_classifier_checker #(
  parameter int unsigned NUM_LEVERS = lpdc_pkg::NUM_LEVERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [lpdc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [lpdc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [lpdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpdc_pkg::TICK_W-1:0]     cfg_data,
  output int unsigned                     fail_count,
  output int unsigned                     results_owed
);

  import lpdc_pkg::*;

  // result fields, lowest bit last
  typedef struct packed {
    logic [FLAG_W-1:0]  flags;
    logic [TICK_W-1:0]  held;
    status_t            status;
    logic [VALUE_W-1:0] value;
    logic [LEVER_W-1:0] lever;
  } tick_result_t;

  localparam int RES_W       = $bits(tick_result_t);
  localparam int MAX_PRINTED = 40;

  // thresholds as last written
  logic [TICK_W-1:0] short_lim;
  logic [TICK_W-1:0] long_lim;
  logic [TICK_W-1:0] very_long_lim;

  // per-lever press tracking
  logic [VALUE_W-1:0] lever_value  [NUM_LEVERS];
  status_t            lever_status [NUM_LEVERS];
  logic [TICK_W-1:0]  lever_timer  [NUM_LEVERS];
  logic [FLAG_W-1:0]  lever_flags  [NUM_LEVERS];

  tick_result_t owed_results [$];
  int unsigned  mismatch_total = 0;

  assign fail_count = mismatch_total;

  task automatic report_mismatch(input string what, input logic [39:0] want,
                                 input logic [39:0] got);
    if (mismatch_total < MAX_PRINTED) begin
      $display("lever press check: %s expected 0x%0h got 0x%0h at %0t", what, want, got,
               $realtime);
    end
    mismatch_total++;
  endtask

  function automatic tick_result_t classify_tick(input logic [LEVER_W-1:0] lever,
                                                 input logic [VALUE_W-1:0] value,
                                                 input logic [FLAG_W-1:0]  mask);
    tick_result_t      res;
    logic [TICK_W-1:0] t;
    int                n;
    n         = int'(lever);
    res.lever = lever;
    if (n >= int'(NUM_LEVERS)) begin
      res.value  = '0;
      res.status = ST_IDLE;
      res.held   = '0;
      res.flags  = '0;
      return res;
    end
    lever_flags[n] = lever_flags[n] & ~mask;
    if (lever_value[n] != value) begin
      lever_value[n] = value;
      if (value != '0) begin
        lever_status[n] = ST_PRESSED;
        lever_timer[n]  = '0;
        lever_flags[n]  = lever_flags[n] & ~FL_PRESS_ALL;
      end else if (lever_timer[n] >= short_lim) begin
        lever_status[n] = ST_POPPED;
        lever_flags[n]  = lever_flags[n] | FL_POP;
      end else begin
        lever_status[n] = ST_IDLE;
      end
    end
    if (lever_status[n] == ST_PRESSED) begin
      t = lever_timer[n];
      if (t != TICK_MAX) t = t + 1'b1;
      lever_timer[n] = t;
      // first match wins: very long, then long, then short
      if (t == very_long_lim) begin
        lever_flags[n] = lever_flags[n] | FL_VLONG;
      end else if (t == long_lim) begin
        lever_flags[n] = lever_flags[n] | FL_LONG;
      end else if (t == short_lim) begin
        lever_flags[n] = lever_flags[n] | FL_SHORT;
      end
      if (t > very_long_lim) lever_status[n] = ST_TIMEOUT;
    end
    res.value  = lever_value[n];
    res.status = lever_status[n];
    res.held   = lever_timer[n];
    res.flags  = lever_flags[n];
    return res;
  endfunction

  task automatic check_result(input logic [OUT_DATA_W-1:0] raw);
    tick_result_t got;
    tick_result_t want;
    got = raw[RES_W-1:0];
    if (owed_results.size() == 0) begin
      report_mismatch("result with nothing owed", '0, raw);
      return;
    end
    want = owed_results.pop_front();
    if (got.lever !== want.lever) report_mismatch("lever_out", want.lever, got.lever);
    if (got.value !== want.value) report_mismatch("current_value", want.value, got.value);
    if (got.status !== want.status) report_mismatch("press_status", want.status, got.status);
    if (got.held !== want.held) report_mismatch("held_ticks", want.held, got.held);
    if (got.flags !== want.flags) report_mismatch("event_flags", want.flags, got.flags);
    if (raw[OUT_DATA_W-1:RES_W] !== '0) begin
      report_mismatch("tdata padding", '0, raw[OUT_DATA_W-1:RES_W]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      short_lim     = SHORT_TICKS_RST;
      long_lim      = LONG_TICKS_RST;
      very_long_lim = VERY_LONG_TICKS_RST;
      for (int i = 0; i < int'(NUM_LEVERS); i++) begin
        lever_value[i]  = '0;
        lever_status[i] = ST_IDLE;
        lever_timer[i]  = '0;
        lever_flags[i]  = '0;
      end
      owed_results.delete();
      results_owed <= 0;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready) begin
        owed_results.push_back(classify_tick(in_tdata[0], in_tdata[16:1], in_tdata[20:17]));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SHORT_TICKS:     short_lim     = cfg_data;
          REG_LONG_TICKS:      long_lim      = cfg_data;
          REG_VERY_LONG_TICKS: very_long_lim = cfg_data;
          default: ;
        endcase
      end
      results_owed <= owed_results.size();
    end
  end

endmodule

// ===== test/lever_press_duration_classifier_test.sv =====
// testbench top for the lever press duration classifier: clock, reset, tick stimulus,
// result sink with random stalls, register writes and the verdict
// depends on lpdc_pkg, lever_press_duration_classifier and its checker
`timescale 1ns / 1ps

module lever_press_duration_classifier_test;

  import lpdc_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int RESET_CYCLES     = 12;
  localparam int DRAIN_CYCLES     = 4;
  localparam int HOLD_CYCLES      = 60;    // long receiver hold-off, fills the block
  localparam int RANDOM_PHASES    = 6;
  localparam int PHASE_ITEMS      = 300;
  localparam int CHUNK_ITEMS      = 50;    // idle modes are redrawn per chunk
  localparam int RUN_LIMIT_CYCLES = 1_000_000;

  // index the block has no register for, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [TICK_W-1:0]     cfg_data   = '0;

  int unsigned fail_count;
  int unsigned results_owed;

  // idling control, shared by the stimulus and the result sink
  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;
  bit hold_req    = 1'b0;

  // thresholds as written, used to shape press lengths
  int thr_short = 10;
  int thr_long  = 200;
  int thr_vlong = 800;

  // per-lever segment generator: a press, a release or a noise sample
  logic [VALUE_W-1:0] seg_val     [2];
  int                 seg_left    [2];
  bit                 seg_pressed [2];

  lever_press_duration_classifier u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lever_press_duration_classifier_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #(RUN_LIMIT_CYCLES * CLK_PERIOD);
    $display("Some tests failed");
    $finish;
  end

  // cycles to wait before the next transaction, zero in stretches without idling
  function automatic int draw_wait(input bit idle_on);
    if (!idle_on || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // one tick transaction; valid stays high straight into the next one when no gap
  task automatic send_tick(input logic lever, input logic [VALUE_W-1:0] value,
                           input logic [FLAG_W-1:0] mask);
    int gap;
    gap = draw_wait(in_idle_on);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, mask, value, lever};
    do @(posedge clk); while (!in_tready);
  endtask

  // the same sample repeated, i.e. a lever held or left alone
  task automatic press_ticks(input logic lever, input logic [VALUE_W-1:0] value,
                             input int count, input logic [FLAG_W-1:0] mask);
    repeat (count) send_tick(lever, value, mask);
  endtask

  // stop sending and wait until every result is back, plus a DRAIN_CYCLES margin
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // valid drops for a cycle after each write so it is never lowered and raised in one step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(input int s, input int l, input int v);
    write_reg(REG_SHORT_TICKS, s[TICK_W-1:0]);
    write_reg(REG_LONG_TICKS, l[TICK_W-1:0]);
    write_reg(REG_VERY_LONG_TICKS, v[TICK_W-1:0]);
    thr_short = s;
    thr_long  = l;
    thr_vlong = v;
  endtask

  // a length one below, at or one above a threshold
  function automatic int around(input int x);
    if (x <= 1) return $urandom_range(1, 2);
    return x - 1 + $urandom_range(0, 2);
  endfunction

  // press lengths aimed at every threshold and at timeout
  function automatic int pick_hold_len();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(1, thr_short);
      1:       return around(thr_short);
      2:       return around(thr_long);
      3:       return around(thr_vlong);
      4:       return thr_vlong + $urandom_range(1, 4);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // mostly press / release sequences per lever, with noise samples mixed in
  task automatic run_random_phase(input int n_items, input bit hold);
    logic              lever;
    logic [FLAG_W-1:0] mask;
    int                r;
    for (int i = 0; i < n_items; i++) begin
      if (i % CHUNK_ITEMS == 0) begin
        if (hold && i == 0) begin
          // keep offering back to back while the sink holds off
          in_idle_on = 1'b0;
          hold_req   = 1'b1;
        end else begin
          in_idle_on = 1'($urandom_range(0, 1));
        end
        out_idle_on = 1'($urandom_range(0, 1));
      end
      lever = 1'($urandom_range(0, 1));
      if (seg_left[lever] == 0) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          // noise: any value for one tick, zero or a nonzero re-press
          seg_val[lever]     = VALUE_W'($urandom);
          seg_left[lever]    = 1;
          seg_pressed[lever] = (seg_val[lever] != '0);
        end else if (seg_pressed[lever]) begin
          seg_val[lever]     = '0;
          seg_left[lever]    = $urandom_range(1, 4);
          seg_pressed[lever] = 1'b0;
        end else begin
          seg_val[lever]     = VALUE_W'($urandom_range(1, 65535));
          seg_left[lever]    = pick_hold_len();
          seg_pressed[lever] = 1'b1;
        end
      end
      seg_left[lever]--;
      mask = ($urandom_range(0, 3) == 0) ? FLAG_W'($urandom) : '0;
      send_tick(lever, seg_val[lever], mask);
    end
  endtask

  // result sink: random stall before each result, or a long hold-off on request
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = draw_wait(out_idle_on);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
        do @(posedge clk); while (!out_tvalid);
      end
    end
  end

  // main sequence
  initial begin
    int s;
    int l;
    int v;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset thresholds: held exactly short_ticks gives the short flag, then a pop
    press_ticks(1'b0, 16'hFFFF, 10, 4'h0);
    press_ticks(1'b0, 16'h0000, 1, 4'h0);
    drain_results();

    // ordered small thresholds
    set_thresholds(2, 3, 4);
    press_ticks(1'b1, 16'h0001, 5, 4'h0);  // short, long, very long flags, then timeout
    press_ticks(1'b1, 16'h0000, 1, 4'h0);  // release after a long hold pops
    press_ticks(1'b1, 16'h8000, 1, 4'h0);  // pop flag survives a new press
    press_ticks(1'b1, 16'h7FFF, 1, 4'h7);  // one nonzero value to another restarts
    press_ticks(1'b1, 16'h0000, 1, 4'hF);  // early release goes idle, mask clears all
    drain_results();

    // all thresholds equal at the minimum: only the very long flag is set
    set_thresholds(1, 1, 1);
    press_ticks(1'b0, 16'h5A5A, 2, 4'h8);
    press_ticks(1'b0, 16'h0000, 1, 4'hF);
    drain_results();

    // write to a register that does not exist, then top-end thresholds
    write_reg(REG_UNUSED, 16'h0001);
    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFE);
    press_ticks(1'b1, 16'h1234, 2, 4'h0);
    press_ticks(1'b1, 16'h0000, 1, 4'h0);
    drain_results();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if ($urandom_range(0, 1)) begin
        s = $urandom_range(1, 6);
        l = s + $urandom_range(0, 8);
        v = l + $urandom_range(0, 10);
      end else begin
        // unordered, so the order of the equality checks shows
        s = $urandom_range(1, 20);
        l = $urandom_range(1, 20);
        v = $urandom_range(1, 20);
      end
      set_thresholds(s, l, v);
      run_random_phase(PHASE_ITEMS, p == 2);
      drain_results();
    end

    if (fail_count == 0 && results_owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== lever_press_duration_classifier.f =====
+incdir+rtl
rtl/lpdc_pkg.sv
rtl/lever_press_duration_classifier.sv
rtl/lpdc_checker.sv
test/lever_press_duration_classifier_checker.sv
test/lever_press_duration_classifier_test.sv
